[rtl/bsu_pkg.sv]
// ---------------------------------------------------------------------------
// bsu_pkg: shared types for the bit stuffer / unstuffer
// Result record, step record between the core and the result queue, and
// register indexes of the configuration port.
// ---------------------------------------------------------------------------
package bsu_pkg;

    localparam int RUN_W     = 4;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    localparam logic [RUN_W-1:0]     RUN_MAX       = '1;
    localparam logic [RUN_W-1:0]     RUN_LIMIT_RST = RUN_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT = CFG_IDX_W'(1);

    typedef enum logic {
        MODE_STUFF   = 1'b0,
        MODE_UNSTUFF = 1'b1
    } t_mode;

    typedef struct packed {
        logic out_bit;
        logic bit_valid;
        logic stuff_error;
        logic last_of_run;
    } t_res;

    // results produced by one input transaction
    typedef struct packed {
        logic push;
        logic two;
        t_res res0;
        t_res res1;
    } t_step;

    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] level;
    } t_qstat;

endpackage

[rtl/bsu_if.sv]
// ---------------------------------------------------------------------------
// bsu_in_if / bsu_out_if: valid-ready channels of the bit stuffer
// Input carries one stream bit and a message start flag, output carries one
// result record.
// ---------------------------------------------------------------------------
interface bsu_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic msg_start;

    modport source (output valid, output data_bit, output msg_start, input ready);
    modport sink   (input valid, input data_bit, input msg_start, output ready);
endinterface

interface bsu_out_if;
    logic valid;
    logic ready;
    logic out_bit;
    logic bit_valid;
    logic stuff_error;
    logic last_of_run;

    modport source (output valid, output out_bit, output bit_valid,
                    output stuff_error, output last_of_run, input ready);
    modport sink   (input valid, input out_bit, input bit_valid,
                    input stuff_error, input last_of_run, output ready);
endinterface

[rtl/bsu_core.sv]
// ---------------------------------------------------------------------------
// bsu_core: configuration registers, run state and per-bit decision
// Counts ones, decides on inserting or dropping a bit and forms the one or
// two result records of each accepted transaction.
// ---------------------------------------------------------------------------
module bsu_core import bsu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_accept,
    input  logic                 i_data_bit,
    input  logic                 i_msg_start,
    output t_step                o_step
);

    t_mode            r_mode;
    logic [RUN_W-1:0] r_run_limit;
    logic [RUN_W-1:0] r_ones_run, n_ones_run;
    logic             r_drop_next, n_drop_next;

    logic [RUN_W-1:0] run0, run_inc;
    logic             drop0, hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STUFF;
            r_run_limit <= RUN_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODE) begin
                r_mode <= t_mode'(i_cfg_data[0]);
            end else if (i_cfg_idx == REG_RUN_LIMIT) begin
                r_run_limit <= i_cfg_data[RUN_W-1:0];
            end
        end
    end

    always_comb begin
        // message start clears the run before this bit is handled
        run0    = i_msg_start ? '0 : r_ones_run;
        drop0   = i_msg_start ? 1'b0 : r_drop_next;
        run_inc = (run0 == RUN_MAX) ? RUN_MAX : run0 + RUN_W'(1);
        hit     = (r_run_limit != '0) && (run_inc == r_run_limit);

        n_ones_run  = i_data_bit ? (hit ? '0 : run_inc) : '0;
        n_drop_next = 1'b0;

        o_step.push = i_accept;
        o_step.two  = 1'b0;
        o_step.res0 = '{out_bit: i_data_bit, bit_valid: 1'b1,
                        stuff_error: 1'b0, last_of_run: 1'b1};
        o_step.res1 = '{out_bit: 1'b0, bit_valid: 1'b1,
                        stuff_error: 1'b0, last_of_run: 1'b1};

        unique case (r_mode)
            MODE_STUFF: begin
                if (i_data_bit && hit) begin
                    o_step.two              = 1'b1;
                    o_step.res0.last_of_run = 1'b0;
                end
            end
            MODE_UNSTUFF: begin
                if (drop0) begin
                    // stuffed position: bit is dropped, a one here is an error
                    n_ones_run  = '0;
                    o_step.res0 = '{out_bit: 1'b0, bit_valid: 1'b0,
                                    stuff_error: i_data_bit, last_of_run: 1'b1};
                end else begin
                    n_drop_next = i_data_bit && hit;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ones_run  <= '0;
            r_drop_next <= 1'b0;
        end else if (i_accept) begin
            r_ones_run  <= n_ones_run;
            r_drop_next <= n_drop_next;
        end
    end

endmodule

[rtl/bsu_res_queue.sv]
// ---------------------------------------------------------------------------
// bsu_res_queue: result queue
// Small ring buffer that takes one or two results per cycle and hands out
// one per cycle while popped; flags room for two so the top never loses input.
// ---------------------------------------------------------------------------
module bsu_res_queue import bsu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_step  i_step,
    input  logic   i_pop,
    output logic   o_valid,
    output t_res   o_res,
    output t_qstat o_stat
);

    t_res              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              pop;
    logic [QPTR_W-1:0] wr_ptr1;
    logic [QCNT_W-1:0] n_push;

    assign pop     = i_pop && (r_count != '0);
    assign wr_ptr1 = r_wr_ptr + QPTR_W'(1);
    assign n_push  = i_step.push ? (i_step.two ? QCNT_W'(2) : QCNT_W'(1)) : '0;

    always_comb begin
        n_wr_ptr = r_wr_ptr + n_push[QPTR_W-1:0];
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + n_push - (pop ? QCNT_W'(1) : QCNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_step.push) begin
            r_mem[r_wr_ptr] <= i_step.res0;
            if (i_step.two) begin
                r_mem[wr_ptr1] <= i_step.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_valid      = (r_count != '0);
    assign o_res        = r_mem[r_rd_ptr];
    assign o_stat.level = r_count;
    assign o_stat.room  = (r_count <= QCNT_W'(QDEPTH - 2));

endmodule

[rtl/bit_stuffer_unstuffer_top.sv]
// ---------------------------------------------------------------------------
// bit_stuffer_unstuffer_top: serial bit stuffer / unstuffer
// Zero insertion or removal after a programmable run of ones.
// ---------------------------------------------------------------------------
// One input bit is accepted per cycle while input ready is high, and its
// results are registered in the result queue. In stuff mode a bit that
// completes a run of run_limit ones yields two results (the bit and an
// inserted zero); the output hands out one result per cycle while the
// receiver is ready, from a four-entry result queue, so inserted zeros
// slow the input. Input ready drops while the queue lacks room for two
// results. Unstuff mode always yields one result per bit; a dropped bit
// shows bit_valid low, with stuff_error high if it was a one.
module bit_stuffer_unstuffer_top import bsu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bsu_in_if.sink               i_in,
    bsu_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_step  step;
    t_qstat qstat;
    t_res   head;
    logic   accept;

    assign i_in.ready = qstat.room;
    assign accept     = i_in.valid && qstat.room;

    bsu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_bit  (i_in.data_bit),
        .i_msg_start (i_in.msg_start),
        .o_step      (step)
    );

    bsu_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_res   (head),
        .o_stat  (qstat)
    );

    assign o_out.out_bit     = head.out_bit;
    assign o_out.bit_valid   = head.bit_valid;
    assign o_out.stuff_error = head.stuff_error;
    assign o_out.last_of_run = head.last_of_run;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level <= QCNT_W'(QDEPTH))
        else $error("result queue level out of range");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> qstat.level <= QCNT_W'(QDEPTH) && qstat.level != '0)
        else $error("accepted transaction left no result queued");

    a_err_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.stuff_error |-> !o_out.bit_valid && o_out.last_of_run)
        else $error("stuff error on a delivered bit");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.bit_valid |-> !o_out.out_bit)
        else $error("dropped bit carries a one");

endmodule

[tb/bit_stuffer_unstuffer_top_tb.sv]
// ---------------------------------------------------------------------------
// bit_stuffer_unstuffer_top_tb: self-checking bench for the bit stuffer
// Drives stream bits through the valid-ready input, predicts every result
// record with a cycle-free model of zero insertion and removal, and checks
// each output transaction in order. Runs directed sequences, then random
// messages over both modes and a spread of run limits, with random idling
// on the sender and stalls on the receiver.
// ---------------------------------------------------------------------------
module bit_stuffer_unstuffer_top_tb import bsu_pkg::*;;

    typedef struct {
        logic data_bit;
        logic msg_start;
    } t_bit_item;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT    = 50;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    bsu_in_if  in_if ();
    bsu_out_if out_if ();

    bit_stuffer_unstuffer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state and its copy of the registers
    t_mode            mdl_mode;
    logic [RUN_W-1:0] mdl_run_limit;
    logic [RUN_W-1:0] mdl_ones;
    logic             mdl_drop;

    t_bit_item   bit_queue[$];
    t_res        expected_results[$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned err_count;
    int unsigned result_count;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic push_result(input logic o, input logic v, input logic e, input logic l);
        t_res r;
        r.out_bit     = o;
        r.bit_valid   = v;
        r.stuff_error = e;
        r.last_of_run = l;
        expected_results = {expected_results, r};
    endtask

    // one more 1 on the run; true when it completes a run of run_limit ones
    function automatic bit run_hits_limit();
        if (mdl_ones != RUN_MAX) mdl_ones = mdl_ones + 1'b1;
        if (mdl_run_limit != '0 && mdl_ones == mdl_run_limit) begin
            mdl_ones = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_stream_bit(input logic b, input logic s);
        if (s) begin
            mdl_ones = '0;
            mdl_drop = 1'b0;
        end
        if (mdl_mode == MODE_STUFF) begin
            mdl_drop = 1'b0;
            if (b && run_hits_limit()) begin
                push_result(1'b1, 1'b1, 1'b0, 1'b0);
                push_result(1'b0, 1'b1, 1'b0, 1'b1);
            end else begin
                if (!b) mdl_ones = '0;
                push_result(b, 1'b1, 1'b0, 1'b1);
            end
        end else if (mdl_drop) begin
            // stuffed position: bit is dropped, a one here is an error
            mdl_drop = 1'b0;
            mdl_ones = '0;
            push_result(1'b0, 1'b0, b, 1'b1);
        end else begin
            if (b) begin
                if (run_hits_limit()) mdl_drop = 1'b1;
            end else begin
                mdl_ones = '0;
            end
            push_result(b, 1'b1, 1'b0, 1'b1);
        end
    endtask

    task automatic add_bit(input logic b, input logic s);
        t_bit_item it;
        it.data_bit  = b;
        it.msg_start = s;
        bit_queue = {bit_queue, it};
    endtask

    // message starting with msg_start; optionally stuffed as a stuffer would
    // do it, with the occasional one in a stuffed position
    task automatic add_message(input int unsigned len, input int unsigned ones_pct,
                               input bit stuffed, input logic [RUN_W-1:0] rl);
        int unsigned run;
        logic        b;
        run = 0;
        for (int unsigned k = 0; k < len; k++) begin
            b = ($urandom_range(99) < ones_pct);
            add_bit(b, k == 0);
            if (b) run++;
            else run = 0;
            if (stuffed && rl != '0 && run == rl) begin
                add_bit($urandom_range(99) < 8, 1'b0);
                run = 0;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_MODE) mdl_mode = t_mode'(val[0]);
        else mdl_run_limit = val[RUN_W-1:0];
    endtask

    task automatic configure(input t_mode m, input logic [RUN_W-1:0] rl);
        logic [CFG_DAT_W-1:0] d;
        // upper data bits are don't-care for the mode register
        d    = CFG_DAT_W'($urandom);
        d[0] = m;
        write_reg(REG_MODE, d);
        write_reg(REG_RUN_LIMIT, CFG_DAT_W'(rl));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained(input int unsigned tail);
        @(negedge i_clk);
        while (bit_queue.size() != 0 || in_if.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_bit_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) predict_stream_bit(in_if.data_bit, in_if.msg_start);
            if (!in_if.valid || in_if.ready) begin
                if (bit_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = bit_queue.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.data_bit  <= nxt.data_bit;
                    in_if.msg_start <= nxt.msg_start;
                end else begin
                    in_if.valid     <= 1'b0;
                    in_if.data_bit  <= 1'($urandom);
                    in_if.msg_start <= 1'($urandom);
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.out_bit !== want.out_bit)
                        report_mismatch($sformatf("result %0d out_bit got %b want %b",
                                                  result_count, out_if.out_bit, want.out_bit));
                    if (out_if.bit_valid !== want.bit_valid)
                        report_mismatch($sformatf("result %0d bit_valid got %b want %b",
                                                  result_count, out_if.bit_valid,
                                                  want.bit_valid));
                    if (out_if.stuff_error !== want.stuff_error)
                        report_mismatch($sformatf("result %0d stuff_error got %b want %b",
                                                  result_count, out_if.stuff_error,
                                                  want.stuff_error));
                    if (out_if.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("result %0d last_of_run got %b want %b",
                                                  result_count, out_if.last_of_run,
                                                  want.last_of_run));
                end
                result_count++;
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL bit_stuffer_unstuffer_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned      pick;
        int unsigned      ones_pct;
        int unsigned      count;
        t_mode            m;
        logic [RUN_W-1:0] rl;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.data_bit  = 1'b0;
        in_if.msg_start = 1'b0;
        out_if.ready    = 1'b0;
        err_count       = 0;
        result_count    = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mdl_mode        = MODE_STUFF;
        mdl_run_limit   = RUN_LIMIT_RST;
        mdl_ones        = '0;
        mdl_drop        = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: stuffing, run of three ones
        add_bit(1'b1, 1'b1);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);   // zero inserted
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b1);   // message start clears the run
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);   // zero inserted
        add_bit(1'b0, 1'b0);
        wait_drained(4);

        configure(MODE_UNSTUFF, RUN_W'(3));
        add_bit(1'b1, 1'b1);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b0);   // stuffed zero dropped
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);   // one in stuffed position
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b1);   // message start cancels the pending drop
        wait_drained(4);

        for (int unsigned p = 0; p < 12; p++) begin
            m = (p % 2 == 0) ? MODE_STUFF : MODE_UNSTUFF;
            case ((p / 2) % 6)
                0: rl = RUN_W'(3);
                1: rl = RUN_W'(1);
                2: rl = RUN_MAX;
                3: rl = '0;
                4: rl = RUN_W'($urandom_range(1, 15));
                default: rl = RUN_W'($urandom_range(0, 15));
            endcase
            ones_pct = (rl == '0 || rl > RUN_W'(10)) ? 92 : $urandom_range(40, 85);

            case ((p + p / 2) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase

            configure(m, rl);
            count = bit_queue.size();
            while (bit_queue.size() - count < 80) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    add_message($urandom_range(4, 24), ones_pct, m == MODE_UNSTUFF, rl);
                end else begin
                    // noise: loose bits with random message starts
                    add_bit(1'($urandom), $urandom_range(99) < 30);
                end
            end
            // leave a drop pending so the next stuffing phase has to ignore it
            if (m == MODE_UNSTUFF && rl != '0) begin
                add_bit(1'b1, 1'b1);
                for (int unsigned k = 1; k < rl; k++) add_bit(1'b1, 1'b0);
            end
            wait_drained(4);
        end

        wait_drained(10);
        if (err_count == 0) begin
            $display("PASS bit_stuffer_unstuffer_top");
        end else begin
            $display("FAIL bit_stuffer_unstuffer_top");
        end
        $finish;
    end

endmodule
